// ----- rtl/rsf_pkg.sv -----
package rsf_pkg;

   // Fixed byte values of the frame format.
   localparam logic [7:0] SYNC_BYTE    = 8'hFF;
   localparam logic [7:0] ACK_CODE     = 8'h41;
   localparam logic [7:0] NAK_CODE     = 8'h4E;
   localparam logic [7:0] BROADCAST_ID = 8'hFE;

   // Command codes with special handling.
   localparam logic [7:0] CMD_READ     = 8'd2;
   localparam logic [7:0] CMD_LAST_ACK = 8'd3;
   localparam logic [7:0] CMD_SILENT   = 8'd4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [9:0] sensor_sample;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } rsp_payload_type;

   // Reply sequencer states: idle, two sync states, then one per remaining reply byte kind.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SYNC_A,
      ST_SYNC_B,
      ST_STATUS,
      ST_ID,
      ST_LEN,
      ST_DATA,
      ST_SUM
   } ctrl_state_type;

   // Receive side framing.
   typedef enum logic [1:0] {
      SYNC_HUNT1,
      SYNC_HUNT2,
      SYNC_FRAME
   } sync_phase_type;

   typedef enum logic [1:0] {
      POS_CMD,
      POS_ID,
      POS_LEN,
      POS_DATA
   } frame_pos_type;

   typedef enum logic [2:0] {
      SEL_SYNC,
      SEL_STATUS,
      SEL_ID,
      SEL_LEN,
      SEL_DATA,
      SEL_SUM
   } byte_sel_type;

   typedef struct packed {
      logic         accept;
      logic         load_out;
      byte_sel_type byte_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic reply_start;
      logic out_free;
      logic len_zero;
      logic data_last;
   } dp_status_type;

endpackage

// ----- rtl/rs485_slave_frame_responder.sv -----
// Channel   Direction  Ports                            Moves
// req       in         req_valid, req_stall, req_payload  received byte and sensor sample
// rsp       out        rsp_valid, rsp_stall, rsp_payload  reply byte and last marker
// csr       in         csr_we, csr_wdata                  station id write
//
// Outside a reply, a byte that does not complete an answered frame is taken in the cycle it is offered.
// A byte that completes an answered frame starts a reply of 6 + length bytes (at most 6 + MAX_PAYLOAD);
// the reply sequencer loads one byte per cycle into the single output register, so input
// is held off until the checksum byte is loaded; while a reply byte waits under rsp_stall,
// no new byte is loaded and input stays held off.
// Synchronous active-high reset returns to sync hunting with station id 1.
module rs485_slave_frame_responder #(
   parameter int MAX_PAYLOAD = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [7:0]               csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  rsf_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsf_pkg::rsp_payload_type rsp_payload
);

   // The controller owns the input handshake and the order of reply bytes.
   // The datapath parses frames, holds the payload store and computes the checksum.
   rsf_pkg::dp_cmd_type    dp_cmd;
   rsf_pkg::dp_status_type dp_status;

   rsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   rsf_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (dp_cmd),
      .status      (dp_status)
   );

endmodule

// ----- rtl/rsf_ctrl.sv -----
module rsf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rsf_pkg::dp_status_type status,
   output rsf_pkg::dp_cmd_type    cmd
);

   rsf_pkg::ctrl_state_type state_ff;
   rsf_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: one reply byte leaves per cycle in which the output register is free.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsf_pkg::ST_IDLE: begin
            if (cmd.accept && status.reply_start) begin
               state_in = rsf_pkg::ST_SYNC_A;
            end
         end
         rsf_pkg::ST_SYNC_A: begin
            if (status.out_free) state_in = rsf_pkg::ST_SYNC_B;
         end
         rsf_pkg::ST_SYNC_B: begin
            if (status.out_free) state_in = rsf_pkg::ST_STATUS;
         end
         rsf_pkg::ST_STATUS: begin
            if (status.out_free) state_in = rsf_pkg::ST_ID;
         end
         rsf_pkg::ST_ID: begin
            if (status.out_free) state_in = rsf_pkg::ST_LEN;
         end
         rsf_pkg::ST_LEN: begin
            if (status.out_free) begin
               state_in = status.len_zero ? rsf_pkg::ST_SUM : rsf_pkg::ST_DATA;
            end
         end
         rsf_pkg::ST_DATA: begin
            if (status.out_free && status.data_last) state_in = rsf_pkg::ST_SUM;
         end
         rsf_pkg::ST_SUM: begin
            if (status.out_free) state_in = rsf_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall    = (state_ff != rsf_pkg::ST_IDLE);
      cmd.accept   = (state_ff == rsf_pkg::ST_IDLE) && req_valid;
      cmd.load_out = (state_ff != rsf_pkg::ST_IDLE) && status.out_free;
      unique case (state_ff)
         rsf_pkg::ST_IDLE:   cmd.byte_sel = rsf_pkg::SEL_SYNC;
         rsf_pkg::ST_SYNC_A: cmd.byte_sel = rsf_pkg::SEL_SYNC;
         rsf_pkg::ST_SYNC_B: cmd.byte_sel = rsf_pkg::SEL_SYNC;
         rsf_pkg::ST_STATUS: cmd.byte_sel = rsf_pkg::SEL_STATUS;
         rsf_pkg::ST_ID:     cmd.byte_sel = rsf_pkg::SEL_ID;
         rsf_pkg::ST_LEN:    cmd.byte_sel = rsf_pkg::SEL_LEN;
         rsf_pkg::ST_DATA:   cmd.byte_sel = rsf_pkg::SEL_DATA;
         rsf_pkg::ST_SUM:    cmd.byte_sel = rsf_pkg::SEL_SUM;
      endcase
   end

   a_reply_begins: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.reply_start |=> state_ff == rsf_pkg::ST_SYNC_A)
      else $error("reply did not start after a completed frame");

   a_sum_ends_reply: assert property (@(posedge clock) disable iff (reset)
      state_ff == rsf_pkg::ST_SUM && cmd.load_out |=> state_ff == rsf_pkg::ST_IDLE)
      else $error("sequencer did not return to idle after the checksum");

   a_no_accept_in_reply: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !cmd.accept)
      else $error("input taken while a reply byte was loaded");

endmodule

// ----- rtl/rsf_datapath.sv -----
module rsf_datapath #(
   parameter int MAX_PAYLOAD = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [7:0]               csr_wdata,
   input  rsf_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsf_pkg::rsp_payload_type rsp_payload,
   input  rsf_pkg::dp_cmd_type      cmd,
   output rsf_pkg::dp_status_type   status
);

   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [IDX_W-1:0] IDX_SECOND = IDX_W'(1 % MAX_PAYLOAD);
   localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_PAYLOAD);

   logic [7:0]               station_id_ff;
   rsf_pkg::sync_phase_type  sync_ff, sync_in;
   rsf_pkg::frame_pos_type   pos_ff, pos_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [7:0]               cmd_code_ff, cmd_code_in;
   logic [7:0]               target_ff, target_in;
   logic [IDX_W-1:0]         em_idx_ff, em_idx_in;
   logic [7:0]               sum_ff, sum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsf_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic [7:0]               store_ff [MAX_PAYLOAD];

   logic [7:0]       rx;
   logic [LEN_W-1:0] pos_next;
   logic             finish;
   logic             store_we;
   logic             sample_we;
   logic [7:0]       status_byte;
   logic [7:0]       tx_sel;

   assign rx       = req_payload.rx_byte;
   assign pos_next = LEN_W'(idx_ff) + LEN_W'(1);

   // Frame parser, advanced once per accepted byte.
   always_comb begin
      sync_in     = sync_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      cmd_code_in = cmd_code_ff;
      target_in   = target_ff;
      finish      = 1'b0;
      store_we    = 1'b0;
      if (cmd.accept) begin
         case (sync_ff)
            rsf_pkg::SYNC_HUNT1: begin
               if (rx == rsf_pkg::SYNC_BYTE) sync_in = rsf_pkg::SYNC_HUNT2;
            end
            rsf_pkg::SYNC_HUNT2: begin
               if (rx == rsf_pkg::SYNC_BYTE) begin
                  sync_in = rsf_pkg::SYNC_FRAME;
                  pos_in  = rsf_pkg::POS_CMD;
               end else begin
                  sync_in = rsf_pkg::SYNC_HUNT1;
               end
            end
            rsf_pkg::SYNC_FRAME: begin
               unique case (pos_ff)
                  rsf_pkg::POS_CMD: begin
                     cmd_code_in = rx;
                     pos_in      = rsf_pkg::POS_ID;
                  end
                  rsf_pkg::POS_ID: begin
                     target_in = rx;
                     pos_in    = rsf_pkg::POS_LEN;
                  end
                  rsf_pkg::POS_LEN: begin
                     if (rx > MAX_LEN_BYTE) begin
                        sync_in = rsf_pkg::SYNC_HUNT1;
                     end else begin
                        len_in = rx[LEN_W-1:0];
                        idx_in = '0;
                        if (rx == 8'd0) begin
                           finish  = 1'b1;
                           sync_in = rsf_pkg::SYNC_HUNT1;
                        end else begin
                           pos_in = rsf_pkg::POS_DATA;
                        end
                     end
                  end
                  rsf_pkg::POS_DATA: begin
                     store_we = 1'b1;
                     if (pos_next >= len_ff) begin
                        finish  = 1'b1;
                        sync_in = rsf_pkg::SYNC_HUNT1;
                     end else begin
                        idx_in = idx_ff + IDX_W'(1);
                     end
                  end
               endcase
            end
            default: sync_in = rsf_pkg::SYNC_HUNT1;
         endcase
      end
   end

   // A completed frame answers only when addressed to this station id, not broadcast, and not silent.
   assign status.reply_start = finish && (cmd_code_ff != rsf_pkg::CMD_SILENT) &&
                               (target_ff != rsf_pkg::BROADCAST_ID) &&
                               (target_ff == station_id_ff);
   assign sample_we = status.reply_start && (cmd_code_ff == rsf_pkg::CMD_READ);

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.len_zero  = (len_ff == '0);
   assign status.data_last = ((LEN_W'(em_idx_ff) + LEN_W'(1)) == len_ff);

   assign status_byte = (cmd_code_ff <= rsf_pkg::CMD_LAST_ACK) ? rsf_pkg::ACK_CODE
                                                               : rsf_pkg::NAK_CODE;

   always_comb begin
      case (cmd.byte_sel)
         rsf_pkg::SEL_SYNC:   tx_sel = rsf_pkg::SYNC_BYTE;
         rsf_pkg::SEL_STATUS: tx_sel = status_byte;
         rsf_pkg::SEL_ID:     tx_sel = target_ff;
         rsf_pkg::SEL_LEN:    tx_sel = 8'(len_ff);
         rsf_pkg::SEL_DATA:   tx_sel = store_ff[em_idx_ff];
         rsf_pkg::SEL_SUM:    tx_sel = sum_ff;
         default:             tx_sel = rsf_pkg::SYNC_BYTE;
      endcase
   end

   // Reply byte index, running checksum and the output register.
   always_comb begin
      em_idx_in      = em_idx_ff;
      sum_in         = sum_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (cmd.accept) begin
         em_idx_in = '0;
         sum_in    = '0;
      end
      if (cmd.load_out) begin
         rsp_valid_in           = 1'b1;
         rsp_payload_in.tx_byte = tx_sel;
         rsp_payload_in.last    = (cmd.byte_sel == rsf_pkg::SEL_SUM);
         if (cmd.byte_sel == rsf_pkg::SEL_DATA) em_idx_in = em_idx_ff + IDX_W'(1);
         if (cmd.byte_sel != rsf_pkg::SEL_SYNC && cmd.byte_sel != rsf_pkg::SEL_SUM) begin
            sum_in = sum_ff + tx_sel;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_id_ff <= 8'd1;
         sync_ff       <= rsf_pkg::SYNC_HUNT1;
         pos_ff        <= rsf_pkg::POS_CMD;
         len_ff        <= LEN_W'(3 % (MAX_PAYLOAD + 1));
         cmd_code_ff   <= '0;
         target_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) station_id_ff <= csr_wdata;
         sync_ff      <= sync_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         cmd_code_ff  <= cmd_code_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      em_idx_ff      <= em_idx_in;
      sum_ff         <= sum_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Payload store; an answered read puts the sample in entries 0 and 1 (0 only if MAX_PAYLOAD=1).
   always_ff @(posedge clock) begin
      if (store_we) store_ff[idx_ff] <= rx;
      if (sample_we) begin
         store_ff[0] <= req_payload.sensor_sample[9:2];
         if (MAX_PAYLOAD > 1) begin
            store_ff[IDX_SECOND] <= {req_payload.sensor_sample[1:0], 6'b0};
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("reply byte loaded over a byte not yet taken");

   a_reply_rehunts: assert property (@(posedge clock) disable iff (reset)
      status.reply_start |=> sync_ff == rsf_pkg::SYNC_HUNT1)
      else $error("parser did not return to sync hunt after a frame");

endmodule
